// ===== hw/rtl/ttsi_pkg.sv =====
// ----------------------------------------------------------------------------
// ttsi_pkg
// Shared types and character constants for the text-to-integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsi_pkg;

    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 32;

    // ASCII codes used by the classifier.
    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_BLANK_HI = 8'h20;
    localparam logic [7:0] CHR_HIGH_LO = 8'h80;
    localparam logic [7:0] CHR_MINUS   = 8'h2D;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UP_A    = 8'h41;
    localparam logic [7:0] CHR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHR_LO_A    = 8'h61;
    localparam logic [7:0] CHR_LO_Z    = 8'h7A;
    localparam logic [7:0] CHR_UP_B    = 8'h42;
    localparam logic [7:0] CHR_UP_D    = 8'h44;
    localparam logic [7:0] CHR_UP_O    = 8'h4F;
    localparam logic [7:0] CHR_UP_X    = 8'h58;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] LETTER_BIAS = 8'd10;

    // Radix values.
    localparam logic [BASE_W-1:0] BASE_NONE = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // Result limits.
    localparam logic [VALUE_W-1:0] POS_CLAMP = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_CLAMP = 32'h8000_0001;
    localparam logic [VALUE_W-1:0] ACC_SAT   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                blank;
        logic                minus;
        logic                zero;
        logic                is_digit;
        logic [DIGIT_W-1:0]  digit;
        logic [BASE_W-1:0]   prefix_base;
    } char_class_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttsi_char_decode.sv =====
// ----------------------------------------------------------------------------
// ttsi_char_decode
// Classifies one input byte: blank, minus, zero, digit value and prefix radix.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsi_char_decode
    import ttsi_pkg::*;
(
    input  wire logic [7:0] char_byte,
    output char_class_t     char_class
);

    logic [7:0] upper;

    // Fold lower-case letters onto upper case.
    assign upper = (char_byte >= CHR_LO_A && char_byte <= CHR_LO_Z) ?
                   (char_byte - CASE_OFFSET) : char_byte;

    always_comb
    begin
        char_class.blank = (char_byte != CHR_NUL) &&
                           ((char_byte <= CHR_BLANK_HI) || (char_byte >= CHR_HIGH_LO));
        char_class.minus = (char_byte == CHR_MINUS);
        char_class.zero  = (char_byte == CHR_ZERO);

        if (upper >= CHR_ZERO && upper <= CHR_NINE)
        begin
            char_class.is_digit = 1'b1;
            char_class.digit    = DIGIT_W'(upper - CHR_ZERO);
        end
        else if (upper >= CHR_UP_A && upper <= CHR_UP_Z)
        begin
            char_class.is_digit = 1'b1;
            char_class.digit    = DIGIT_W'(upper - CHR_UP_A + LETTER_BIAS);
        end
        else
        begin
            char_class.is_digit = 1'b0;
            char_class.digit    = '0;
        end

        unique case (upper)
            CHR_UP_B: char_class.prefix_base = BASE_BIN;
            CHR_UP_D: char_class.prefix_base = BASE_DEC;
            CHR_UP_O: char_class.prefix_base = BASE_OCT;
            CHR_UP_X: char_class.prefix_base = BASE_HEX;
            default:  char_class.prefix_base = BASE_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/text_to_signed_integer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// text_to_signed_integer_parser_unit
// Streaming strtol-style parser: bytes in, one signed 32-bit result per string.
// ----------------------------------------------------------------------------
// The block takes one byte of text per clock cycle unless stalled, and
// returns one item per string when the first byte that is not a digit of the
// radix arrives. Each byte is decoded and folded into the parse state; the
// clock period is set by the accumulate step, one 32-by-6-bit multiply-add
// of the accumulator by the radix plus the saturation check. The result is
// registered in the cycle after the byte that ends the number, and the input
// keeps accepting bytes while that result waits, as long as the output
// register is empty or being drained in the same cycle. Bytes before the
// first start and after a result are swallowed without output. The radix
// register is sampled on each start byte, so it may be rewritten between
// strings. The end offset counts consumed bytes from the start byte and
// stops at POSITION_LIMIT; only its low eight bits are reported.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_signed_integer_parser_unit
    import ttsi_pkg::*;
#(
    parameter int POSITION_LIMIT = 255
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Radix register.
    input  wire logic              cfg_we,
    input  wire logic [BASE_W-1:0] cfg_wdata,     // number_base

    // Byte stream in.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,       // [7:0] char_byte
    input  wire logic              s_tuser,       // [0] string_start

    // Result stream out.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata        // [31:0] value, [32] range_error,
                                                  // [40:33] end_offset, rest zero
);

    localparam int POS_W = (POSITION_LIMIT < 2) ? 1 : $clog2(POSITION_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_LIMIT);
    localparam int SUM_W = VALUE_W + BASE_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                cons_reg, cons_next;
    logic [BASE_W-1:0]   number_base_reg;

    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                err_reg, err_next;
    logic [7:0]          offset_reg, offset_next;

    char_class_t         cc;
    logic                accept;
    logic                active;
    logic                handled;
    logic                emit;
    logic [SUM_W-1:0]    sum;

    ttsi_char_decode u_decode
    (
        .char_byte  (s_tdata),
        .char_class (cc)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Parse step for one byte. The phases fall through within the cycle: a
    // lead byte that is neither blank nor minus moves on to the post-sign check
    // and then on to digit handling without consuming itself.
    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        cons_next   = cons_reg;
        active      = 1'b1;
        handled     = 1'b0;
        emit        = 1'b0;
        sum         = '0;
        value_next  = acc_reg;
        err_next    = ovf_reg;
        offset_next = '0;

        if (s_tuser)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            base_next  = number_base_reg;
            pos_next   = '0;
            cons_next  = 1'b0;
        end
        else if (phase_reg == PH_IDLE || phase_reg == PH_DONE)
        begin
            active = 1'b0;
        end

        if (active && phase_next == PH_LEAD)
        begin
            if (cc.blank)
            begin
                handled = 1'b1;
            end
            else if (cc.minus)
            begin
                neg_next   = 1'b1;
                phase_next = PH_AFTER_SIGN;
                handled    = 1'b1;
            end
            else
            begin
                phase_next = PH_AFTER_SIGN;
            end
        end

        if (active && !handled && phase_next == PH_AFTER_SIGN)
        begin
            if (cc.blank)
            begin
                handled = 1'b1;
            end
            else if (cc.zero)
            begin
                cons_next  = 1'b1;
                phase_next = PH_ZERO;
                handled    = 1'b1;
            end
            else
            begin
                if (base_next == BASE_NONE)
                begin
                    base_next = BASE_DEC;
                end
                phase_next = PH_DIGITS;
            end
        end
        else if (active && !handled && phase_next == PH_ZERO)
        begin
            if (base_next == BASE_NONE)
            begin
                base_next = (cc.prefix_base != BASE_NONE) ? cc.prefix_base : BASE_OCT;
            end
            phase_next = PH_DIGITS;
            // A prefix letter that names the radix in use is skipped.
            if (cc.prefix_base == base_next)
            begin
                handled = 1'b1;
            end
        end

        if (active && !handled)
        begin
            if (!cc.is_digit || cc.digit >= base_next)
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                sum = SUM_W'(acc_next) * SUM_W'(base_next) + SUM_W'(cc.digit);
                if (sum[SUM_W-1:VALUE_W] != '0)
                begin
                    ovf_next = 1'b1;
                    acc_next = ACC_SAT;
                end
                else
                begin
                    acc_next = sum[VALUE_W-1:0];
                end
                cons_next = 1'b1;
                handled   = 1'b1;
            end
        end

        // Every consumed byte advances the position, up to the limit.
        if (active && handled && pos_next < POS_MAX)
        begin
            pos_next = pos_next + POS_W'(1);
        end

        // Result formatting: magnitudes of 2^31 and above clamp, for either sign.
        if (acc_next[VALUE_W-1])
        begin
            err_next   = 1'b1;
            value_next = neg_next ? NEG_CLAMP : POS_CLAMP;
        end
        else
        begin
            err_next   = ovf_next;
            value_next = neg_next ? (VALUE_W'(0) - acc_next) : acc_next;
        end
        offset_next = cons_next ? 8'(pos_next) : 8'd0;
    end

    always_comb
    begin
        if (accept && emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            base_reg        <= BASE_NONE;
            pos_reg         <= '0;
            cons_reg        <= 1'b0;
            number_base_reg <= BASE_NONE;
            m_valid_reg     <= 1'b0;
            value_reg       <= '0;
            err_reg         <= 1'b0;
            offset_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                number_base_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                cons_reg  <= cons_next;
            end
            if (accept && emit)
            begin
                value_reg  <= value_next;
                err_reg    <= err_next;
                offset_reg <= offset_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, offset_reg, err_reg, value_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/ttsi_checker.sv =====
// ----------------------------------------------------------------------------
// ttsi_checker
// Port-level checks for the text-to-integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsi_checker
    import ttsi_pkg::*;
#(
    parameter int POSITION_LIMIT = 255
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [47:0]       m_tdata
);

    // A result held back by the sink must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output stage always takes the next byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A range error always comes with one of the two clamp values.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |->
            (m_tdata[31:0] == POS_CLAMP) || (m_tdata[31:0] == NEG_CLAMP))
        else $error("range error without clamped value");

    // Nothing consumed means a plain zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[40:33] == 8'd0) && (POSITION_LIMIT < 256) |->
            (m_tdata[31:0] == 32'd0) && !m_tdata[32])
        else $error("nonzero result with zero end offset");

endmodule

bind text_to_signed_integer_parser_unit ttsi_checker #(
    .POSITION_LIMIT (POSITION_LIMIT)
) u_ttsi_checker (.*);

`default_nettype wire
